FILE: src/efp_pkg.sv
`default_nettype none
package efp_pkg;

   localparam int FIELD_BUFFER_BYTES = 64;
   localparam int CHAR_CNT_W         = $clog2(FIELD_BUFFER_BYTES);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_R_UP  = 8'h52;
   localparam logic [7:0] CH_R_LO  = 8'h72;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;

   localparam logic [18:0] DATA_MASK_SHORT = 19'h3ffff;
   localparam logic [18:0] DATA_MASK_LONG  = 19'h7ffff;

   typedef struct packed {
      logic [7:0] raw;
      logic       blank;
      logic       sign;
      logic       minus;
      logic       digit;
      logic [3:0] digit_value;
      logic       comma;
   } token_type;

   typedef enum logic [1:0] {
      PHASE_LEAD,
      PHASE_DIGITS,
      PHASE_DONE
   } phase_type;

   typedef struct packed {
      logic [18:0] data_value;
      logic        trailing_zero;
      logic        parity_bit;
      logic        decoder_error;
      logic        signal_watchdog;
      logic        quadrature_error;
      logic        decoder_status;
      logic [31:0] frame_count;
      logic        overflow;
   } result_type;

   typedef struct packed {
      logic                   valid;
      logic                   full;
      logic [QUEUE_CNT_W-1:0] count;
   } queue_status_type;

endpackage
`default_nettype wire

FILE: src/encoder_frame_parser.sv
`default_nettype none
// Serial frame parser for an absolute encoder.
// req_ channel: one received character per word on req_rx_byte, taken when
// req_valid is high and req_stall low. The parser hunts for the header *0R0
// (letter in either case), then reads a decimal field up to a comma: leading
// white space skipped, optional sign, digits up to the first non-digit, the
// 32-bit value wrapping.
// rsp_ channel: one word per comma, with flags from value bits 4..0, data
// bits from bit 5 on, the status bit and the good-frame count. A field of
// too many characters gives a word with rsp_overflow set and all else zero.
// csr_ port: csr_write_data is the short data mode bit, written when
// csr_write_enable is high (18 data bits and status at bit 24 when set).
// Throughput: one character per cycle while req_stall is low. A character
// is written into a four-word queue, then read by the parser, which
// registers the word for a comma in the output register behind rsp_valid.
// When the receiver stalls, the result waits in the output register; the
// parser keeps taking characters that give no result, and req_stall rises
// once the queue is full.
// Reset clears the mode, the frame count, the queue and the parser, which
// then hunts for a header.
module encoder_frame_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [18:0]      rsp_data_value,
   output logic             rsp_trailing_zero,
   output logic             rsp_parity_bit,
   output logic             rsp_decoder_error,
   output logic             rsp_signal_watchdog,
   output logic             rsp_quadrature_error,
   output logic             rsp_decoder_status,
   output logic [31:0]      rsp_frame_count,
   output logic             rsp_overflow,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);
   import efp_pkg::*;

   logic             short_mode_ff, short_mode_in;
   queue_status_type queue_status;
   token_type        push_token;
   token_type        pop_token;
   logic             push;
   logic             pop;
   result_type       rsp;

   assign short_mode_in = csr_write_enable ? csr_write_data : short_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_mode_ff <= 1'b0;
      end else begin
         short_mode_ff <= short_mode_in;
      end
   end

   efp_front u_front (
      .req_valid    (req_valid),
      .req_rx_byte  (req_rx_byte),
      .req_stall    (req_stall),
      .queue_status (queue_status),
      .push         (push),
      .token        (push_token)
   );

   efp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_token),
      .pop       (pop),
      .pop_data  (pop_token),
      .status    (queue_status)
   );

   efp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .token_valid (queue_status.valid),
      .token       (pop_token),
      .short_mode  (short_mode_ff),
      .pop         (pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign rsp_data_value       = rsp.data_value;
   assign rsp_trailing_zero    = rsp.trailing_zero;
   assign rsp_parity_bit       = rsp.parity_bit;
   assign rsp_decoder_error    = rsp.decoder_error;
   assign rsp_signal_watchdog  = rsp.signal_watchdog;
   assign rsp_quadrature_error = rsp.quadrature_error;
   assign rsp_decoder_status   = rsp.decoder_status;
   assign rsp_frame_count      = rsp.frame_count;
   assign rsp_overflow         = rsp.overflow;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_overflow_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> (rsp_frame_count == 32'd0) && (rsp_data_value == 19'd0))
      else $error("overflow word carries data");

   a_no_word_from_nothing: assert property (@(posedge clock) disable iff (reset)
      !queue_status.valid && !rsp_valid |=> !rsp_valid)
      else $error("result word without a queued character");

   a_full_queue_stalls: assert property (@(posedge clock) disable iff (reset)
      queue_status.full && !pop |=> queue_status.full)
      else $error("queue drained without a pop");

endmodule
`default_nettype wire

FILE: src/efp_front.sv
`default_nettype none
module efp_front (
   input  wire logic                      req_valid,
   input  wire logic [7:0]                req_rx_byte,
   output logic                           req_stall,
   input  wire efp_pkg::queue_status_type queue_status,
   output logic                           push,
   output efp_pkg::token_type             token
);
   import efp_pkg::*;

   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full;

   always_comb begin
      token             = '0;
      token.raw         = req_rx_byte;
      token.blank       = (req_rx_byte == CH_SPACE) ||
                          ((req_rx_byte >= CH_TAB) && (req_rx_byte <= CH_CR));
      token.sign        = (req_rx_byte == CH_PLUS) || (req_rx_byte == CH_MINUS);
      token.minus       = (req_rx_byte == CH_MINUS);
      token.digit       = (req_rx_byte >= CH_ZERO) && (req_rx_byte <= CH_NINE);
      token.digit_value = req_rx_byte[3:0];
      token.comma       = (req_rx_byte == CH_COMMA);
   end

endmodule
`default_nettype wire

FILE: src/efp_queue.sv
`default_nettype none
module efp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire efp_pkg::token_type   push_data,
   input  wire logic                 pop,
   output efp_pkg::token_type        pop_data,
   output efp_pkg::queue_status_type status
);
   import efp_pkg::*;

   token_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign do_push = push && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule
`default_nettype wire

FILE: src/efp_back.sv
`default_nettype none
module efp_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          token_valid,
   input  wire efp_pkg::token_type token,
   input  wire logic          short_mode,
   output logic               pop,
   input  wire logic          rsp_stall,
   output logic               rsp_valid,
   output efp_pkg::result_type rsp
);
   import efp_pkg::*;

   logic [31:0]           window_ff, window_in;
   logic                  in_field_ff, in_field_in;
   logic [31:0]           acc_ff, acc_in;
   logic                  negative_ff, negative_in;
   phase_type             phase_ff, phase_in;
   logic [CHAR_CNT_W-1:0] count_ff, count_in;
   logic [31:0]           good_ff, good_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;

   logic [31:0] shifted;
   logic        header_hit;
   logic        field_full;
   logic        emit;
   logic        restart;
   logic [31:0] acc_times_ten;
   logic [31:0] value;
   result_type  result;

   assign shifted    = {window_ff[23:0], token.raw};
   assign header_hit = (shifted[31:24] == CH_STAR) && (shifted[23:16] == CH_ZERO) &&
                       ((shifted[15:8] == CH_R_UP) || (shifted[15:8] == CH_R_LO)) &&
                       (shifted[7:0] == CH_ZERO);
   assign field_full = (count_ff >= CHAR_CNT_W'(FIELD_BUFFER_BYTES - 1));
   assign emit       = in_field_ff && (field_full || token.comma);
   // a word with no result never waits on the output side
   assign pop        = token_valid && (!emit || !rsp_valid_ff || !rsp_stall);
   assign acc_times_ten = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} +
                          {28'd0, token.digit_value};

   // next state
   always_comb begin
      window_in   = window_ff;
      in_field_in = in_field_ff;
      acc_in      = acc_ff;
      negative_in = negative_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      good_in     = good_ff;
      restart     = 1'b0;
      if (pop) begin
         if (!in_field_ff) begin
            window_in = shifted;
            if (header_hit) begin
               restart     = 1'b1;
               in_field_in = 1'b1;
            end
         end else if (field_full || token.comma) begin
            restart     = 1'b1;
            in_field_in = 1'b0;
            if (!field_full) begin
               good_in = good_ff + 32'd1;
            end
         end else begin
            count_in = count_ff + 1'b1;
            case (phase_ff)
               PHASE_LEAD: begin
                  if (token.sign) begin
                     negative_in = token.minus;
                     phase_in    = PHASE_DIGITS;
                  end else if (!token.blank) begin
                     if (token.digit) begin
                        acc_in   = acc_times_ten;
                        phase_in = PHASE_DIGITS;
                     end else begin
                        phase_in = PHASE_DONE;
                     end
                  end
               end
               PHASE_DIGITS: begin
                  if (token.digit) begin
                     acc_in = acc_times_ten;
                  end else begin
                     phase_in = PHASE_DONE;
                  end
               end
               default: begin
                  phase_in = PHASE_DONE;
               end
            endcase
         end
         if (restart) begin
            window_in   = '0;
            acc_in      = '0;
            negative_in = 1'b0;
            phase_in    = PHASE_LEAD;
            count_in    = '0;
         end
      end
   end

   // result word
   always_comb begin
      value  = negative_ff ? (32'd0 - acc_ff) : acc_ff;
      result = '0;
      if (field_full) begin
         result.overflow = 1'b1;
      end else begin
         result.data_value       = value[23:5] & (short_mode ? DATA_MASK_SHORT : DATA_MASK_LONG);
         result.trailing_zero    = value[0];
         result.parity_bit       = value[1];
         result.decoder_error    = value[2];
         result.signal_watchdog  = value[3];
         result.quadrature_error = value[4];
         result.decoder_status   = short_mode ? value[24] : value[25];
         result.frame_count      = good_ff + 32'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         in_field_ff  <= 1'b0;
         acc_ff       <= '0;
         negative_ff  <= 1'b0;
         phase_ff     <= PHASE_LEAD;
         count_ff     <= '0;
         good_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         in_field_ff  <= in_field_in;
         acc_ff       <= acc_in;
         negative_ff  <= negative_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import efp_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_WORDS  = 1850;

   // Predicts the decoded frame words from the received characters.
   class frame_predictor;
      logic        short_mode = 1'b0;
      logic [31:0] window = '0;
      logic        in_field = 1'b0;
      logic [31:0] accum = '0;
      logic        negative = 1'b0;
      phase_type   phase = PHASE_LEAD;
      int unsigned field_chars = 0;
      logic [31:0] good_frames = '0;
      result_type  expected[$];
      int          errors = 0;
      int          checked = 0;

      function void restart();
         in_field    = 1'b0;
         window      = '0;
         accum       = '0;
         negative    = 1'b0;
         phase       = PHASE_LEAD;
         field_chars = 0;
      endfunction

      function void take_char(logic [7:0] c);
         if (phase == PHASE_LEAD) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
               return;
            phase = PHASE_DIGITS;
            if (c == CH_PLUS || c == CH_MINUS) begin
               negative = (c == CH_MINUS);
               return;
            end
         end
         if (phase == PHASE_DIGITS) begin
            if (c >= CH_ZERO && c <= CH_NINE)
               accum = accum * 32'd10 + 32'(c - CH_ZERO);
            else
               phase = PHASE_DONE;
         end
      endfunction

      function void note_byte(logic [7:0] c);
         result_type  r;
         logic [31:0] v;
         r = '0;
         if (!in_field) begin
            window = {window[23:0], c};
            if (window[31:24] == CH_STAR && window[23:16] == CH_ZERO &&
                (window[15:8] == CH_R_UP || window[15:8] == CH_R_LO) &&
                window[7:0] == CH_ZERO) begin
               restart();
               in_field = 1'b1;
            end
            return;
         end
         // a character that would overrun the field buffer aborts the frame
         if (field_chars + 1 > FIELD_BUFFER_BYTES - 1) begin
            r.overflow = 1'b1;
            expected.push_back(r);
            restart();
            return;
         end
         field_chars++;
         if (c != CH_COMMA) begin
            take_char(c);
            return;
         end
         v = negative ? 32'd0 - accum : accum;
         good_frames++;
         r.data_value       = v[23:5] & (short_mode ? DATA_MASK_SHORT : DATA_MASK_LONG);
         r.trailing_zero    = v[0];
         r.parity_bit       = v[1];
         r.decoder_error    = v[2];
         r.signal_watchdog  = v[3];
         r.quadrature_error = v[4];
         r.decoder_status   = short_mode ? v[24] : v[25];
         r.frame_count      = good_frames;
         expected.push_back(r);
         restart();
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         $display("word %0d %s: got %0h, expected %0h", checked, what, got, want);
         errors++;
      endfunction

      function void field_check(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report(name, got, want);
      endfunction

      function void check_frame(result_type got);
         result_type want;
         checked++;
         if (expected.size() == 0) begin
            report("arrived with nothing pending", got.frame_count, '0);
            return;
         end
         want = expected.pop_front();
         field_check("data_value", 32'(got.data_value), 32'(want.data_value));
         field_check("trailing_zero", 32'(got.trailing_zero), 32'(want.trailing_zero));
         field_check("parity_bit", 32'(got.parity_bit), 32'(want.parity_bit));
         field_check("decoder_error", 32'(got.decoder_error), 32'(want.decoder_error));
         field_check("signal_watchdog", 32'(got.signal_watchdog),
                     32'(want.signal_watchdog));
         field_check("quadrature_error", 32'(got.quadrature_error),
                     32'(want.quadrature_error));
         field_check("decoder_status", 32'(got.decoder_status), 32'(want.decoder_status));
         field_check("frame_count", got.frame_count, want.frame_count);
         field_check("overflow", 32'(got.overflow), 32'(want.overflow));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [18:0] rsp_data_value;
   logic        rsp_trailing_zero;
   logic        rsp_parity_bit;
   logic        rsp_decoder_error;
   logic        rsp_signal_watchdog;
   logic        rsp_quadrature_error;
   logic        rsp_decoder_status;
   logic [31:0] rsp_frame_count;
   logic        rsp_overflow;
   logic        csr_write_enable;
   logic        csr_write_data;

   frame_predictor frames = new;
   logic [7:0]     char_stream[$];
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             words_sent = 0;
   int             quiet_cycles = 0;
   result_type     seen_word;

   encoder_frame_parser i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_data_value       (rsp_data_value),
      .rsp_trailing_zero    (rsp_trailing_zero),
      .rsp_parity_bit       (rsp_parity_bit),
      .rsp_decoder_error    (rsp_decoder_error),
      .rsp_signal_watchdog  (rsp_signal_watchdog),
      .rsp_quadrature_error (rsp_quadrature_error),
      .rsp_decoder_status   (rsp_decoder_status),
      .rsp_frame_count      (rsp_frame_count),
      .rsp_overflow         (rsp_overflow),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset)
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_word = {rsp_data_value, rsp_trailing_zero, rsp_parity_bit,
                         rsp_decoder_error, rsp_signal_watchdog, rsp_quadrature_error,
                         rsp_decoder_status, rsp_frame_count, rsp_overflow};
            frames.check_frame(seen_word);
         end
         if (req_valid && !req_stall)
            frames.note_byte(req_rx_byte);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic [7:0] any_but_comma();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CH_COMMA)
         b = CH_PLUS;
      return b;
   endfunction

   function automatic void add_text(string s);
      foreach (s[i])
         char_stream.push_back(8'(s[i]));
   endfunction

   // Mostly well-formed frames with random content; some noise, broken
   // headers and overlong fields.
   function automatic void add_frame();
      int          kind;
      int          style;
      logic [31:0] v;
      string       digits;
      kind = $urandom_range(99);
      if ($urandom_range(4) == 0)
         repeat ($urandom_range(1, 3)) char_stream.push_back(8'($urandom_range(255)));
      if (kind < 5) begin
         repeat ($urandom_range(1, 6)) char_stream.push_back(8'($urandom_range(255)));
         return;
      end
      char_stream.push_back(CH_STAR);
      char_stream.push_back(CH_ZERO);
      char_stream.push_back($urandom_range(1) ? CH_R_UP : CH_R_LO);
      char_stream.push_back(CH_ZERO);
      if (kind < 12)
         char_stream[char_stream.size() - 1 - $urandom_range(3)] = 8'($urandom_range(255));
      if (kind < 18 && kind >= 12) begin
         // either side of the buffer limit
         repeat ($urandom_range(60, 70)) char_stream.push_back(any_but_comma());
         char_stream.push_back(CH_COMMA);
         return;
      end
      repeat ($urandom_range(2))
         char_stream.push_back($urandom_range(1) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
      case ($urandom_range(2))
         1: char_stream.push_back(CH_PLUS);
         2: char_stream.push_back(CH_MINUS);
         default: ;
      endcase
      style = $urandom_range(9);
      if (style >= 1 && style <= 5) begin
         v = $urandom;
         add_text($sformatf("%0d", v));
      end else if (style >= 6 && style <= 7) begin
         v = $urandom_range(4095);
         add_text($sformatf("%0d", v));
      end else if (style >= 8) begin
         // long strings wrap the 32-bit value
         repeat ($urandom_range(1, 14)) char_stream.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) char_stream.push_back(any_but_comma());
      char_stream.push_back(CH_COMMA);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_stream();
      foreach (char_stream[i])
         send_byte(char_stream[i]);
      words_sent += char_stream.size();
      char_stream.delete();
      req_valid = 1'b0;
   endtask

   // Hold off the sender until every pending word is out and the queue is empty.
   task automatic drain();
      req_valid = 1'b0;
      while (frames.expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_write_enable  = 1'b1;
      csr_write_data    = mode;
      frames.short_mode = mode;
      @(negedge clock);
      csr_write_enable  = 1'b0;
   endtask

   initial begin
      int chunk_words;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_mode(1'b0);
      // all ones, lower-case header, tab before a minus sign
      add_text("*0r0");
      char_stream.push_back(CH_TAB);
      add_text("-1,");
      // NUL ends the number, later digit is ignored
      add_text("*0R0 7");
      char_stream.push_back(8'h00);
      add_text("9,");
      add_text("*0R0,");
      add_text("*0R0-12");
      send_stream();
      // change mode in the middle of a field
      drain();
      write_mode(1'b1);
      add_text("34,");
      send_stream();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 58 : 0;
         recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 33 : 0;
         for (int chunk = 0; chunk < 3; chunk++) begin
            drain();
            write_mode(1'((ph + chunk) % 2));
            chunk_words = 0;
            while (chunk_words < RANDOM_WORDS / 9) begin
               add_frame();
               chunk_words += char_stream.size();
               send_stream();
            end
         end
      end

      req_valid = 1'b0;
      while (frames.expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (frames.errors == 0 && frames.expected.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
